FILE: rtl/core/cml_pkg.sv
`default_nettype none
package cml_pkg;

    localparam int LATTICE_SIZE_DEF = 10;
    localparam int OUTPUT_CELL_DEF  = 5;

    localparam int PERIOD_W   = 40;
    localparam int RATE_W     = 32;
    localparam int COUPLING_W = 31;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int MUL_W      = 34;
    localparam int PROD_W     = 2 * MUL_W;

    localparam logic [PERIOD_W-1:0]   PERIOD_RST = 40'd65536;
    localparam logic [RATE_W-1:0]     RATE_RST   = 32'd1610612736;
    localparam logic [COUPLING_W-1:0] COUP_RST   = 31'd107374182;
    localparam logic [VALUE_W-1:0]    INIT_RST   = 32'd107374182;
    localparam logic [PERIOD_W-1:0]   ONE_Q16    = 40'd65536;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_PERIOD   = 2'd0,
        REG_GROWTH_RATE   = 2'd1,
        REG_COUPLING      = 2'd2,
        REG_INITIAL_VALUE = 2'd3
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_SQ,
        OP_RQ,
        OP_FIN,
        OP_T1,
        OP_T2,
        OP_SUM,
        OP_EMIT
    } t_op;

    // Destination of a finished map value
    typedef enum logic [1:0] {
        FD_LEFT,
        FD_CENTER,
        FD_RIGHT
    } t_fdst;

    typedef struct packed {
        t_op   op;
        logic  restart;
        logic  src_new;
        t_fdst dest;
    } t_cmd;

    typedef struct packed {
        logic adv;
    } t_sts;

    function automatic t_value sat_q(input logic signed [39:0] v);
        t_value r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cml_if.sv
`default_nettype none
interface cml_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface cml_out_if;
    logic                  valid;
    logic                  ready;
    cml_pkg::t_value       sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/cml_ram.sv
`default_nettype none
module cml_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/cml_datapath.sv
`default_nettype none
module cml_datapath #(
    parameter int LATTICE_SIZE = cml_pkg::LATTICE_SIZE_DEF,
    parameter int OUTPUT_CELL  = cml_pkg::OUTPUT_CELL_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [cml_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [cml_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire cml_pkg::t_cmd                   i_cmd,
    input  wire logic [$clog2(LATTICE_SIZE)-1:0] i_raddr,
    input  wire logic [$clog2(LATTICE_SIZE)-1:0] i_waddr,
    output cml_pkg::t_sts                        o_sts,
    output cml_pkg::t_value                      o_sample
);

    localparam int IDX_W   = $clog2(LATTICE_SIZE);
    localparam int OUT_IDX = (OUTPUT_CELL < LATTICE_SIZE) ? OUTPUT_CELL : LATTICE_SIZE - 1;
    localparam int MW      = cml_pkg::MUL_W;
    localparam int PW      = cml_pkg::PROD_W;

    logic [cml_pkg::PERIOD_W-1:0]   r_period;
    logic [cml_pkg::RATE_W-1:0]     r_rate;
    logic [cml_pkg::COUPLING_W-1:0] r_coup;
    logic [cml_pkg::VALUE_W-1:0]    r_init;
    logic [cml_pkg::PERIOD_W-1:0]   r_phase;
    logic [LATTICE_SIZE-1:0]        r_valid;
    cml_pkg::t_value                r_fill;
    cml_pkg::t_value                r_mirror;

    logic                           r_rd_valid;
    logic signed [PW-1:0]           r_prod;
    logic signed [33:0]             r_t1;
    cml_pkg::t_value                r_new;
    cml_pkg::t_value                r_fl;
    cml_pkg::t_value                r_fc;
    cml_pkg::t_value                r_fr;
    cml_pkg::t_value                r_sample;

    logic [cml_pkg::VALUE_W-1:0]    w_rdata;
    cml_pkg::t_value                w_y;
    logic signed [MW-1:0]           w_mul_a;
    logic signed [MW-1:0]           w_mul_b;
    logic signed [PW-1:0]           w_prod;
    logic [32:0]                    w_sq;
    logic [35:0]                    w_rq;
    logic signed [39:0]             w_fv;
    cml_pkg::t_value                w_f;
    logic signed [32:0]             w_fs;
    logic signed [33:0]             w_t1;
    logic signed [33:0]             w_t2;
    logic signed [35:0]             w_sum;
    cml_pkg::t_value                w_new;
    logic [cml_pkg::PERIOD_W-1:0]   w_ph0;
    logic                           w_adv;
    logic [cml_pkg::PERIOD_W-1:0]   w_ph_next;

    cml_ram #(
        .WIDTH (cml_pkg::VALUE_W),
        .DEPTH (LATTICE_SIZE)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == cml_pkg::OP_SUM),
        .i_waddr (i_waddr),
        .i_wdata (w_new),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    // A cell not written since restart holds the fill value
    assign w_y = i_cmd.src_new ? r_new : (r_rd_valid ? cml_pkg::t_value'(w_rdata) : r_fill);

    always_comb begin
        case (i_cmd.op)
            cml_pkg::OP_SQ: begin
                w_mul_a = {{(MW-32){w_y[31]}}, w_y};
                w_mul_b = {{(MW-32){w_y[31]}}, w_y};
            end
            cml_pkg::OP_RQ: begin
                w_mul_a = $signed({{(MW-32){1'b0}}, r_rate});
                w_mul_b = $signed({{(MW-33){1'b0}}, w_sq});
            end
            cml_pkg::OP_T1: begin
                w_mul_a = $signed(34'd1073741824 - {{(MW-31){1'b0}}, r_coup});
                w_mul_b = {{(MW-32){r_fc[31]}}, r_fc};
            end
            cml_pkg::OP_T2: begin
                w_mul_a = $signed({{(MW-31){1'b0}}, r_coup});
                w_mul_b = {{(MW-33){w_fs[32]}}, w_fs};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Round half up, then shift down by 30
    assign w_sq  = r_prod[62:30] + 33'(r_prod[29]);
    assign w_rq  = 36'(r_prod[64:30]) + 36'(r_prod[29]);
    assign w_fv  = 40'sd1073741824 - $signed({4'b0, w_rq});
    assign w_f   = cml_pkg::sat_q(w_fv);

    assign w_fs  = $signed({r_fl[31], r_fl}) + $signed({r_fr[31], r_fr});
    assign w_t1  = $signed(r_prod[63:30]) + $signed({33'b0, r_prod[29]});
    assign w_t2  = $signed(r_prod[64:31]) + $signed({33'b0, r_prod[30]});
    assign w_sum = {{2{r_t1[33]}}, r_t1} + {{2{w_t2[33]}}, w_t2};
    assign w_new = cml_pkg::sat_q({{4{w_sum[35]}}, w_sum});

    assign w_ph0     = i_cmd.restart ? '0 : r_phase;
    assign w_adv     = (w_ph0 >= r_period);
    assign w_ph_next = (w_adv ? (w_ph0 - r_period) : w_ph0) + cml_pkg::ONE_Q16;

    assign o_sts.adv = w_adv;
    assign o_sample  = r_sample;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= cml_pkg::PERIOD_RST;
            r_rate   <= cml_pkg::RATE_RST;
            r_coup   <= cml_pkg::COUP_RST;
            r_init   <= cml_pkg::INIT_RST;
            r_phase  <= '0;
            r_valid  <= '0;
            r_fill   <= '0;
            r_mirror <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (cml_pkg::t_cfg_reg'(i_cfg_idx))
                    cml_pkg::REG_STEP_PERIOD:   r_period <= i_cfg_data[39:0];
                    cml_pkg::REG_GROWTH_RATE:   r_rate   <= i_cfg_data[31:0];
                    cml_pkg::REG_COUPLING:      r_coup   <= i_cfg_data[30:0];
                    cml_pkg::REG_INITIAL_VALUE: r_init   <= i_cfg_data[31:0];
                    default: ;
                endcase
            end
            case (i_cmd.op)
                cml_pkg::OP_ACCEPT: begin
                    r_phase <= w_ph_next;
                    if (i_cmd.restart) begin
                        r_valid  <= '0;
                        r_fill   <= cml_pkg::t_value'(r_init);
                        r_mirror <= cml_pkg::t_value'(r_init);
                    end
                end
                cml_pkg::OP_SUM: begin
                    r_valid[i_waddr] <= 1'b1;
                    if (i_waddr == IDX_W'(OUT_IDX)) begin
                        r_mirror <= w_new;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[i_raddr];
        case (i_cmd.op) inside
            cml_pkg::OP_SQ, cml_pkg::OP_RQ, cml_pkg::OP_T1: begin
                r_prod <= w_prod;
            end
            cml_pkg::OP_T2: begin
                r_t1   <= w_t1;
                r_prod <= w_prod;
            end
            cml_pkg::OP_FIN: begin
                case (i_cmd.dest)
                    cml_pkg::FD_LEFT:   r_fl <= w_f;
                    cml_pkg::FD_CENTER: r_fc <= w_f;
                    cml_pkg::FD_RIGHT:  r_fr <= w_f;
                    default: ;
                endcase
            end
            cml_pkg::OP_SUM: begin
                r_new <= w_new;
                r_fc  <= r_fr;
            end
            cml_pkg::OP_EMIT: begin
                r_sample <= r_mirror;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/core/cml_ctrl.sv
`default_nettype none
module cml_ctrl #(
    parameter int LATTICE_SIZE = cml_pkg::LATTICE_SIZE_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    input  wire logic                            i_in_restart,
    output logic                                 o_in_ready,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    input  wire cml_pkg::t_sts                   i_sts,
    output cml_pkg::t_cmd                        o_cmd,
    output logic [$clog2(LATTICE_SIZE)-1:0]      o_raddr,
    output logic [$clog2(LATTICE_SIZE)-1:0]      o_waddr
);

    localparam int IDX_W = $clog2(LATTICE_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LATTICE_SIZE - 2);

    typedef enum logic [3:0] {
        S_IDLE,
        S_READ,
        S_SQR,
        S_RQ,
        S_FIN,
        S_T1,
        S_T2,
        S_SUM,
        S_DONE
    } t_state;

    t_state             r_state;
    t_state             n_state;
    logic [IDX_W-1:0]   r_idx;
    logic [IDX_W-1:0]   n_idx;
    logic [IDX_W-1:0]   r_addr;
    logic [IDX_W-1:0]   n_addr;
    cml_pkg::t_fdst     r_kind;
    cml_pkg::t_fdst     n_kind;
    logic               r_src_new;
    logic               n_src_new;
    logic               r_out_valid;
    logic               n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_raddr     = r_addr;
    assign o_waddr     = r_idx;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_addr      = r_addr;
        n_kind      = r_kind;
        n_src_new   = r_src_new;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd.op      = cml_pkg::OP_NONE;
        o_cmd.restart = i_in_restart;
        o_cmd.src_new = r_src_new;
        o_cmd.dest    = r_kind;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = cml_pkg::OP_ACCEPT;
                    if (i_sts.adv) begin
                        n_addr    = '0;
                        n_kind    = cml_pkg::FD_LEFT;
                        n_src_new = 1'b0;
                        n_state   = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_READ: n_state = S_SQR;
            S_SQR: begin
                o_cmd.op = cml_pkg::OP_SQ;
                n_state  = S_RQ;
            end
            S_RQ: begin
                o_cmd.op = cml_pkg::OP_RQ;
                n_state  = S_FIN;
            end
            S_FIN: begin
                o_cmd.op = cml_pkg::OP_FIN;
                unique case (r_kind)
                    cml_pkg::FD_LEFT: begin
                        n_src_new = 1'b0;
                        n_kind    = cml_pkg::FD_RIGHT;
                        n_state   = S_READ;
                        if (r_src_new) begin
                            // next cell: its right neighbour comes from memory
                            n_idx  = r_idx + IDX_W'(1);
                            n_addr = r_idx + IDX_W'(2);
                        end else begin
                            n_addr = IDX_W'(1);
                            n_kind = cml_pkg::FD_CENTER;
                        end
                    end
                    cml_pkg::FD_CENTER: begin
                        n_idx   = IDX_W'(1);
                        n_addr  = IDX_W'(2);
                        n_kind  = cml_pkg::FD_RIGHT;
                        n_state = S_READ;
                    end
                    default: n_state = S_T1;
                endcase
            end
            S_T1: begin
                o_cmd.op = cml_pkg::OP_T1;
                n_state  = S_T2;
            end
            S_T2: begin
                o_cmd.op = cml_pkg::OP_T2;
                n_state  = S_SUM;
            end
            S_SUM: begin
                o_cmd.op = cml_pkg::OP_SUM;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DONE;
                end else begin
                    n_kind    = cml_pkg::FD_LEFT;
                    n_src_new = 1'b1;
                    n_state   = S_SQR;
                end
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.op    = cml_pkg::OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_addr      <= '0;
            r_kind      <= cml_pkg::FD_LEFT;
            r_src_new   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_addr      <= n_addr;
            r_kind      <= n_kind;
            r_src_new   <= n_src_new;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/coupled_map_lattice_oscillator.sv
// Chaotic oscillator built on a coupled lattice of logistic maps.
// i_in carries one item per sample tick (restart flag); o_out returns one
// sample item per tick, the output cell after the tick. Both use valid/ready.
// The config port writes step_period, growth_rate, coupling and
// initial_value by index 0..3; the user must write them only while the
// block is idle, as the block itself does not enforce it. A tick that
// does not advance the lattice skips the update and goes from acceptance
// to the done state, which hands its sample to the output register. For a
// tick that advances it, the single shared 34x34 multiplier runs six
// products per inner cell, in order (two map evaluations and two coupling
// terms), plus one more map evaluation and reads of the left and centre cells from memory for the first inner cell.
// A new item is taken as soon as the previous one has been handed to the
// output register, even if the receiver has not taken that sample yet; if
// the receiver stalls, the next finished item waits until the register is free.
// Reset clears all cells and the phase counter and loads the register
// defaults; no clearing pass is needed. Restart reloads every cell from
// initial_value at acceptance.
`default_nettype none
module coupled_map_lattice_oscillator #(
    parameter int LATTICE_SIZE = cml_pkg::LATTICE_SIZE_DEF,
    parameter int OUTPUT_CELL  = cml_pkg::OUTPUT_CELL_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    cml_in_if.sink                              i_in,
    cml_out_if.source                           o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [cml_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [cml_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(LATTICE_SIZE);

    cml_pkg::t_cmd      w_cmd;
    cml_pkg::t_sts      w_sts;
    logic [IDX_W-1:0]   w_raddr;
    logic [IDX_W-1:0]   w_waddr;

    cml_ctrl #(
        .LATTICE_SIZE (LATTICE_SIZE)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_in_restart (i_in.restart),
        .o_in_ready   (i_in.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .i_sts        (w_sts),
        .o_cmd        (w_cmd),
        .o_raddr      (w_raddr),
        .o_waddr      (w_waddr)
    );

    cml_datapath #(
        .LATTICE_SIZE (LATTICE_SIZE),
        .OUTPUT_CELL  (OUTPUT_CELL)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_raddr    (w_raddr),
        .i_waddr    (w_waddr),
        .o_sts      (w_sts),
        .o_sample   (o_out.sample)
    );

endmodule
`default_nettype wire

FILE: rtl/core/cml_checker.sv
`default_nettype none
module cml_checker (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_in_valid,
    input wire logic            i_in_ready,
    input wire logic            i_out_valid,
    input wire logic            i_out_ready,
    input wire cml_pkg::t_value i_out_sample
);

    // one item at a time: ready drops right after an item is taken
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while an item is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_sample)))
        else $error("stalled sample changed or dropped");

    // a new sample only ends a busy period
    a_out_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(!i_in_ready))
        else $error("sample appeared without an item in flight");

    a_ready_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("block not ready after handing off a sample");

endmodule

bind coupled_map_lattice_oscillator cml_checker u_cml_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample)
);
`default_nettype wire

FILE: test/cml_sample_checker.sv
module cml_sample_checker
    import cml_pkg::*;
#(
    parameter int LATTICE_SIZE = LATTICE_SIZE_DEF,
    parameter int OUTPUT_CELL  = OUTPUT_CELL_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_in_restart,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_value                i_out_sample,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_advances,
    output int                    o_checked
);

    localparam int TAP_CELL = (OUTPUT_CELL < LATTICE_SIZE) ? OUTPUT_CELL : LATTICE_SIZE - 1;
    localparam logic signed [79:0] UNITY      = 80'sd1073741824;
    localparam logic signed [79:0] HALF_UNITY = 80'sd536870912;

    logic [PERIOD_W-1:0]   period_q16;
    logic [RATE_W-1:0]     rate_q30;
    logic [COUPLING_W-1:0] coup_q30;
    logic [VALUE_W-1:0]    seed_q30;

    t_value              lattice [LATTICE_SIZE];
    logic [PERIOD_W-1:0] phase_q16;

    t_value expected_samples [$];
    int     fail_total    = 0;
    int     advance_total = 0;
    int     checked_total = 0;

    function automatic t_value clamp_q30(input logic signed [79:0] v);
        if (v > 80'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -80'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // f(y) = 1 - r*y*y, both products rounded half up
    function automatic logic signed [79:0] logistic_map(input t_value y);
        logic signed [79:0] ys;
        logic signed [79:0] yy;
        logic [79:0]        sq;
        logic [79:0]        rq;
        ys = y;
        yy = ys * ys;
        sq = (yy + HALF_UNITY) >>> 30;
        rq = (rate_q30 * sq + 80'd536870912) >> 30;
        return clamp_q30(UNITY - $signed(rq));
    endfunction

    // Update inner cells left to right in place; the left neighbour is already new.
    function automatic void advance_lattice();
        logic signed [79:0] gg;
        logic signed [79:0] fc;
        logic signed [79:0] fs;
        logic signed [79:0] t1;
        logic signed [79:0] t2;
        gg = $signed({49'd0, coup_q30});
        for (int i = 1; i < LATTICE_SIZE - 1; i++) begin
            fc = logistic_map(lattice[i]);
            fs = logistic_map(lattice[i-1]) + logistic_map(lattice[i+1]);
            t1 = ((UNITY - gg) * fc + HALF_UNITY) >>> 30;
            t2 = (gg * fs + UNITY) >>> 31;
            lattice[i] = clamp_q30(t1 + t2);
        end
    endfunction

    function automatic t_value oscillator_tick(input logic restart);
        if (restart) begin
            foreach (lattice[k]) begin
                lattice[k] = seed_q30;
            end
            phase_q16 = '0;
        end
        if (phase_q16 >= period_q16) begin
            phase_q16 = phase_q16 - period_q16;
            advance_lattice();
            advance_total++;
        end
        phase_q16 = phase_q16 + ONE_Q16;
        return lattice[TAP_CELL];
    endfunction

    task automatic mismatch_report(input string msg);
        fail_total++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin
        t_value want;
        if (!i_rst_n) begin
            period_q16 = PERIOD_RST;
            rate_q30   = RATE_RST;
            coup_q30   = COUP_RST;
            seed_q30   = INIT_RST;
            foreach (lattice[k]) begin
                lattice[k] = '0;
            end
            phase_q16 = '0;
            expected_samples.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_STEP_PERIOD:   period_q16 = i_cfg_data[PERIOD_W-1:0];
                    REG_GROWTH_RATE:   rate_q30   = i_cfg_data[RATE_W-1:0];
                    REG_COUPLING:      coup_q30   = i_cfg_data[COUPLING_W-1:0];
                    REG_INITIAL_VALUE: seed_q30   = i_cfg_data[VALUE_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                expected_samples.push_back(oscillator_tick(i_in_restart));
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_samples.size() == 0) begin
                    mismatch_report($sformatf("sample %0d arrived with no tick outstanding",
                                              i_out_sample));
                end else begin
                    want = expected_samples.pop_front();
                    checked_total++;
                    if (i_out_sample !== want) begin
                        mismatch_report($sformatf("sample %0d: got %0d, want %0d",
                                                  checked_total, i_out_sample, want));
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_samples.size();
        o_advances   <= advance_total;
        o_checked    <= checked_total;
    end

endmodule

FILE: test/coupled_map_lattice_oscillator_tb.sv
module coupled_map_lattice_oscillator_tb;
    import cml_pkg::*;

    localparam int RANDOM_PHASES   = 7;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int IDLE_LIMIT      = 3000;
    localparam int DRAIN_CYCLES    = 100;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int advances;
    int checked;
    int tick_total    = 0;
    int restart_total = 0;
    int setting_total = 0;
    int quiet_cycles  = 0;
    bit tx_idle_on    = 1'b0;
    bit rx_stall_on   = 1'b0;

    cml_in_if  in_ch ();
    cml_out_if out_ch ();

    coupled_map_lattice_oscillator dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    cml_sample_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_restart (in_ch.restart),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_sample (out_ch.sample),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_advances   (advances),
        .o_checked    (checked)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mostly short stalls, now and then a long one
    function automatic int gap_cycles(input int long_max);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, long_max);
    endfunction

    // Sample receiver
    initial begin
        int n;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!rx_stall_on) begin
                out_ch.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
                n = gap_cycles(120);
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("watchdog: %0d cycles without an item moving, %0d samples outstanding",
                     quiet_cycles, pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_tick(input bit restart);
        in_ch.valid   <= 1'b1;
        in_ch.restart <= restart;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        tick_total++;
        if (restart) begin
            restart_total++;
        end
    endtask

    task automatic idle_gap();
        int n;
        n = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 45) begin
            n = gap_cycles(80);
        end
        if (n > 0) begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every sample has come back
    task automatic settle();
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(input logic [PERIOD_W-1:0] period,
                                 input logic [RATE_W-1:0] rate,
                                 input logic [COUPLING_W-1:0] coup,
                                 input logic [VALUE_W-1:0] seed);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_STEP_PERIOD;
        i_cfg_data <= period;
        @(posedge i_clk);
        i_cfg_idx  <= REG_GROWTH_RATE;
        i_cfg_data <= {8'd0, rate};
        @(posedge i_clk);
        i_cfg_idx  <= REG_COUPLING;
        i_cfg_data <= {9'd0, coup};
        @(posedge i_clk);
        i_cfg_idx  <= REG_INITIAL_VALUE;
        i_cfg_data <= {8'd0, seed};
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        setting_total++;
    endtask

    // Restart flags taken LSB first
    task automatic run_pattern(input logic [7:0] restarts, input int count);
        for (int k = 0; k < count; k++) begin
            send_tick(restarts[k]);
            idle_gap();
        end
    endtask

    initial begin
        logic [PERIOD_W-1:0]   per;
        logic [RATE_W-1:0]     rate;
        logic [COUPLING_W-1:0] coup;
        logic [VALUE_W-1:0]    seed;
        int                    wait_cycles;

        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_STEP_PERIOD;
        i_cfg_data    <= '0;
        in_ch.valid   <= 1'b0;
        in_ch.restart <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: start from all-zero cells, then restart mid-way
        run_pattern(8'b0000_1000, 6);

        // Zero period, rate and coupling at their top, most negative seed
        settle();
        load_settings('0, 32'hffff_ffff, 31'h7fff_ffff, 32'h8000_0000);
        run_pattern(8'b0000_0001, 4);

        // Largest period never lets the lattice move; zero rate and coupling
        settle();
        load_settings(40'hff_ffff_ffff, '0, '0, 32'h7fff_ffff);
        run_pattern(8'b0000_0001, 3);

        // Fractional period, r = 2, g = 1, seed -1.0, with stalls on both sides
        settle();
        tx_idle_on  = 1'b1;
        rx_stall_on = 1'b1;
        load_settings(40'd98304, 32'h8000_0000, 31'h4000_0000, 32'hc000_0000);
        run_pattern(8'b0000_0001, 6);

        // Period just below one, seed zero
        settle();
        load_settings(40'd65535, 32'd2040109466, 31'h2000_0000, '0);
        run_pattern(8'b0000_1001, 5);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            settle();
            case ($urandom_range(0, 9))
                0:       per = '0;
                1:       per = {8'($urandom_range(0, 255)), 32'($urandom)};
                default: per = 40'($urandom_range(16384, 262144));
            endcase
            rate = ($urandom_range(0, 4) != 0) ? 32'($urandom_range(0, 32'h8000_0000))
                                               : 32'($urandom);
            coup = ($urandom_range(0, 4) != 0) ? 31'($urandom_range(0, 32'h4000_0000))
                                               : 31'($urandom);
            seed = ($urandom_range(0, 1) != 0) ? 32'($urandom)
                 : 32'($urandom_range(0, 32'h8000_0000)) - 32'h4000_0000;
            tx_idle_on  = ($urandom_range(0, 3) != 0);
            rx_stall_on = ($urandom_range(0, 3) != 0);
            load_settings(per, rate, coup, seed);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_tick((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 24) == 0));
                if ($urandom_range(0, 49) == 0) begin
                    settle();
                end else begin
                    idle_gap();
                end
            end
        end

        in_ch.valid <= 1'b0;
        wait_cycles = 0;
        do begin
            @(posedge i_clk);
            wait_cycles++;
        end while (pending != 0 && wait_cycles < 20000);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending != 0) begin
            $display("%0d expected samples never arrived", pending);
        end
        $display("coverage: %0d ticks (%0d with restart) over %0d register settings",
                 tick_total, restart_total, setting_total);
        $display("coverage: %0d lattice updates, %0d samples compared", advances, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/cml_pkg.sv
rtl/core/cml_if.sv
rtl/core/cml_ram.sv
rtl/core/cml_datapath.sv
rtl/core/cml_ctrl.sv
rtl/core/coupled_map_lattice_oscillator.sv
rtl/core/cml_checker.sv
test/cml_sample_checker.sv
test/coupled_map_lattice_oscillator_tb.sv
